>>> src/sorted_set_table_macros.svh
// Assertion helpers used by the sorted set table RTL.
`ifndef SORTED_SET_TABLE_MACROS_SVH
`define SORTED_SET_TABLE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SST_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sst_pkg.sv
`default_nettype none

package sst_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 32;

	// request codes; the unused code behaves as a search
	localparam logic [1:0] MODE_SEARCH = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	// completion codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_DUP    = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [KEY_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [4:0] position;
		logic [1:0] status;
		logic [4:0] entry_count;
	} rsp_t;

endpackage

`default_nettype wire

>>> src/sst_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module sst_ram #(
	parameter int WIDTH = sst_pkg::KEY_W,
	parameter int DEPTH = sst_pkg::CAPACITY_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> src/sorted_set_table.sv
// Sorted set table: holds up to CAPACITY distinct signed 32-bit keys in
// ascending order and serves one search, insert or remove per transaction.
// Request channel (req_valid / req_stall / req): a transaction is taken when
// req_valid is high and req_stall is low. req_stall stays high while a
// request is being worked on, so requests are handled one at a time.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one response per
// request. The response sits in an output register; a new request is taken
// as soon as the previous one is finished, even while its response is still
// stalled. A finished request waits only while the held response is stalled.
// Timing is set by a single RAM read port and one key comparator that walk
// the table one entry per cycle, then the same port shifts entries one per
// cycle. The walk stops at the first entry not below the key. An insert then
// shifts the entries from that position up by one and stores the key; a
// remove of a present key shifts the entries above it down by one; a search
// or a refused request moves no entry. The next request can be taken in the
// cycle after the response is loaded, so transactions never overlap.
// Reset empties the table (count to zero) and drops any pending response;
// the key storage is not cleared, since only entries below the count are used.
`default_nettype none

`include "sorted_set_table_macros.svh"

module sorted_set_table #(
	parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_stall,
	input  wire sst_pkg::req_t req,
	output logic              rsp_valid,
	input  wire logic         rsp_stall,
	output sst_pkg::rsp_t     rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CMP    = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_INS_SH = 7'b0001000,
		S_WRKEY  = 7'b0010000,
		S_DEL_SH = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// control state
	logic [CNT_W-1:0] count_q, count_d;
	logic             rsp_valid_q, rsp_valid_d;

	// per-request working registers
	logic [1:0]                       mode_q;
	logic signed [sst_pkg::KEY_W-1:0] key_q;
	logic [CNT_W-1:0]                 idx_q, idx_d;
	logic [CNT_W-1:0]                 pos_q, pos_d;
	logic                             hit_q, hit_d;
	logic [1:0]                       status_q, status_d;
	sst_pkg::rsp_t                    rsp_q;

	logic take_req;
	logic rsp_load;

	// RAM port
	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	logic [sst_pkg::KEY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]          ram_raddr;
	logic [sst_pkg::KEY_W-1:0] ram_rdata;

	// shared index arithmetic and key comparator
	logic [CNT_W:0]   idx_p1, idx_p2, pos_p1, count_x;
	logic [CNT_W-1:0] idx_m1, idx_m2, count_m1;
	logic             key_gt, key_eq;
	logic [31:0]      pos_ext, count_ext;

	assign idx_p1   = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign idx_p2   = {1'b0, idx_q} + (CNT_W+1)'(2);
	assign pos_p1   = {1'b0, pos_q} + (CNT_W+1)'(1);
	assign count_x  = {1'b0, count_q};
	assign idx_m1   = idx_q - CNT_W'(1);
	assign idx_m2   = idx_q - CNT_W'(2);
	assign count_m1 = count_q - CNT_W'(1);
	assign key_gt   = key_q > $signed(ram_rdata);
	assign key_eq   = key_q == $signed(ram_rdata);

	assign pos_ext   = 32'(pos_q);
	assign count_ext = 32'(count_q);

	sst_ram #(
		.WIDTH(sst_pkg::KEY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer. The read address issued in one state is the entry the next
	// state consumes; each walk or shift step prefetches the entry for the next.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		hit_d     = hit_q;
		status_d  = status_q;
		take_req  = 1'b0;
		rsp_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				// entry 0 is being read for the first compare
				if (req_valid) begin
					take_req = 1'b1;
					idx_d    = '0;
					status_d = sst_pkg::ST_DONE;
					if (count_q == '0) begin
						pos_d   = '0;
						hit_d   = 1'b0;
						state_d = S_DECIDE;
					end else begin
						state_d = S_CMP;
					end
				end
			end
			S_CMP: begin
				// prefetch the next entry while comparing this one
				ram_raddr = idx_p1[IDX_W-1:0];
				if (key_gt) begin
					if (idx_p1 < count_x) begin
						idx_d = idx_p1[CNT_W-1:0];
					end else begin
						pos_d   = idx_p1[CNT_W-1:0];
						hit_d   = 1'b0;
						state_d = S_DECIDE;
					end
				end else begin
					pos_d   = idx_q;
					hit_d   = key_eq;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				if (mode_q == sst_pkg::MODE_INSERT) begin
					// last entry is the first to move up
					ram_raddr = count_m1[IDX_W-1:0];
					if (hit_q) begin
						status_d = sst_pkg::ST_DUP;
					end else if (count_q == CNT_W'(CAPACITY)) begin
						status_d = sst_pkg::ST_FULL;
					end else if (pos_q == count_q) begin
						state_d = S_WRKEY;
					end else begin
						idx_d   = count_q;
						state_d = S_INS_SH;
					end
				end else if (mode_q == sst_pkg::MODE_REMOVE) begin
					// entry after the hit is the first to move down
					ram_raddr = pos_p1[IDX_W-1:0];
					if (!hit_q) begin
						status_d = sst_pkg::ST_ABSENT;
					end else begin
						count_d = count_m1;
						if (pos_p1 < count_x) begin
							idx_d   = pos_q;
							state_d = S_DEL_SH;
						end
					end
				end
			end
			S_INS_SH: begin
				ram_raddr = idx_m2[IDX_W-1:0];
				ram_we    = 1'b1;
				if (idx_m1 == pos_q) begin
					state_d = S_WRKEY;
				end else begin
					idx_d = idx_m1;
				end
			end
			S_WRKEY: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[IDX_W-1:0];
				ram_wdata = key_q;
				count_d   = count_q + CNT_W'(1);
				state_d   = S_DONE;
			end
			S_DEL_SH: begin
				// count already holds the reduced value here
				ram_raddr = idx_p2[IDX_W-1:0];
				ram_we    = 1'b1;
				if (idx_p1 < count_x) begin
					idx_d = idx_p1[CNT_W-1:0];
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_valid_d = rsp_valid_q;
		if (rsp_load) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			mode_q <= req.mode;
			key_q  <= req.value;
		end
		idx_q    <= idx_d;
		pos_q    <= pos_d;
		hit_q    <= hit_d;
		status_q <= status_d;
		if (rsp_load) begin
			rsp_q.found       <= hit_q;
			rsp_q.position    <= pos_ext[4:0];
			rsp_q.status      <= status_q;
			rsp_q.entry_count <= count_ext[4:0];
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the table never holds more entries than it has room for
	`SST_ASSERT_ALWAYS(a_count_cap, clk, arst_n, count_q <= CNT_W'(CAPACITY), "count above capacity")
	// an accepted request starts the walk or goes straight to the decision
	`SST_ASSERT_NXT(a_req_start, clk, arst_n, req_valid && !req_stall, (state_q == S_CMP) || (state_q == S_DECIDE), "request did not start")
	// a response appears only when a request finishes
	`SST_ASSERT_IMP(a_rsp_src, clk, arst_n, $rose(rsp_valid), $past(state_q == S_DONE), "response without finished request")
	// the table is written only by the shift and store steps
	`SST_ASSERT_IMP(a_write_states, clk, arst_n, ram_we, (state_q == S_INS_SH) || (state_q == S_WRKEY) || (state_q == S_DEL_SH), "table write outside update")

endmodule

`default_nettype wire

>>> tb/sv/tb_sorted_set_table.sv
`timescale 1ns / 100ps

module tb_sorted_set_table;

	import sst_pkg::*;

	// The spare request code has no name in the package; the block treats it as a search.
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int unsigned RANDOM_ITEMS = 1225;
	// Receiver hold-off long enough to back the block up into its request port.
	localparam int unsigned LONG_HOLD    = 400;
	// Idle cycles at the end of the run; a margin over the slowest request.
	localparam int unsigned TAIL_CYCLES  = 48;
	// Quiet cycles allowed before giving up: several times the long hold plus a full walk.
	localparam int unsigned QUIET_LIMIT  = 3000;

	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	// Mirror of the sorted table plus the queue of responses still owed by the block.
	class sorted_set_scoreboard;
		logic signed [KEY_W-1:0] keys [CAPACITY_DEF];
		int unsigned             key_count;
		rsp_t                    awaited [$];
		int unsigned             mismatches;
		int unsigned             checked;
		int unsigned             full_hits;
		int unsigned             status_tally [4];

		function new();
			key_count  = 0;
			mismatches = 0;
			checked    = 0;
			full_hits  = 0;
			foreach (status_tally[s])
				status_tally[s] = 0;
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		// Draw a key that is in the table right now, or any key if the table is empty.
		function logic signed [KEY_W-1:0] pick_stored_key();
			if (key_count == 0)
				return $urandom;
			return keys[$urandom_range(key_count - 1)];
		endfunction

		// Apply one accepted request to the mirror and queue the response it must produce.
		function void note_request(req_t item);
			rsp_t                    outcome;
			logic signed [KEY_W-1:0] key;
			int unsigned             slot;
			bit                      hit;
			key  = item.value;
			slot = 0;
			// walk to the first stored key not less than the request key
			while (slot < key_count && key > keys[slot])
				slot++;
			hit            = (slot < key_count) && (keys[slot] == key);
			outcome.status = ST_DONE;
			case (item.mode)
				MODE_INSERT: begin
					if (hit)
						outcome.status = ST_DUP;
					else if (key_count >= CAPACITY_DEF)
						outcome.status = ST_FULL;
					else begin
						for (int i = key_count; i > slot; i--)
							keys[i] = keys[i - 1];
						keys[slot] = key;
						key_count++;
						if (key_count == CAPACITY_DEF)
							full_hits++;
					end
				end
				MODE_REMOVE: begin
					if (hit) begin
						for (int i = slot; i + 1 < key_count; i++)
							keys[i] = keys[i + 1];
						key_count--;
					end else
						outcome.status = ST_ABSENT;
				end
				default: ;  // search and the spare code leave the table alone
			endcase
			outcome.found       = hit;
			outcome.position    = 5'(slot);
			outcome.entry_count = 5'(key_count);
			status_tally[outcome.status]++;
			awaited.push_back(outcome);
		endfunction

		// Compare one accepted response with the oldest owed one, field by field.
		function void check_response(rsp_t seen);
			rsp_t want;
			if (awaited.size() == 0) begin
				$error("response with no request outstanding: %p", seen);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (seen.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, seen.found);
				mismatches++;
			end
			if (seen.position !== want.position) begin
				$error("position: expected %0d, got %0d", want.position, seen.position);
				mismatches++;
			end
			if (seen.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, seen.status);
				mismatches++;
			end
			if (seen.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count,
					seen.entry_count);
				mismatches++;
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	sorted_set_scoreboard board;
	int unsigned          requests_taken = 0;
	int unsigned          burst_left     = 0;

	sorted_set_table #(
		.CAPACITY (CAPACITY_DEF)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Check every response transaction at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_response(rsp);
	end

	// Drop valid for the given number of cycles; with drain set, also hold off
	// until the block owes nothing.
	task automatic pause_sender(input int unsigned cycles, input bit drain);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
		while (drain && board.outstanding() != 0)
			@(posedge clk);
	endtask

	// Offer one request, hold it until accepted, note it, then pace the next one.
	task automatic send(input logic [1:0] mode, input logic signed [KEY_W-1:0] value);
		req_t item;
		item.mode  = mode;
		item.value = value;
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		board.note_request(item);
		requests_taken++;
		if (burst_left > 0)
			burst_left--;
		else begin
			// mostly short bursts, now and then a long unbroken stretch
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(80, 30)
				: $urandom_range(12);
			pause_sender($urandom_range(8, 1), 1'b0);
		end
	endtask

	// Random traffic in rounds: each round picks a key source and a lean toward
	// filling or draining, so the table sweeps between empty and full.
	task automatic run_random(input int unsigned target);
		int unsigned             issued;
		int unsigned             round_len;
		int unsigned             key_style;
		int unsigned             lean;
		int unsigned             roll;
		logic [1:0]              mode;
		logic signed [KEY_W-1:0] base;
		logic signed [KEY_W-1:0] value;
		issued = 0;
		while (issued < target) begin
			round_len = $urandom_range(80, 15);
			key_style = $urandom_range(2);
			lean      = $urandom_range(2);
			base      = $urandom;
			while (round_len > 0 && issued < target) begin
				roll = $urandom_range(99);
				case (lean)
					0:       mode = (roll < 35) ? MODE_INSERT : (roll < 70) ? MODE_REMOVE
						: (roll < 95) ? MODE_SEARCH : MODE_SPARE;
					1:       mode = (roll < 60) ? MODE_INSERT : (roll < 75) ? MODE_REMOVE
						: (roll < 95) ? MODE_SEARCH : MODE_SPARE;
					default: mode = (roll < 15) ? MODE_INSERT : (roll < 75) ? MODE_REMOVE
						: (roll < 95) ? MODE_SEARCH : MODE_SPARE;
				endcase
				// hit stored keys often enough to exercise removes, duplicates and hits
				roll = $urandom_range(99);
				if (roll < ((mode == MODE_INSERT) ? 20 : 50))
					value = board.pick_stored_key();
				else begin
					case (key_style)
						0:       value = base + $urandom_range(23);
						1:       value = $urandom;
						default: begin
							case ($urandom_range(7))
								0:       value = KEY_MIN;
								1:       value = KEY_MIN + 1;
								2:       value = -1;
								3:       value = 0;
								4:       value = 1;
								5:       value = KEY_MAX - 1;
								6:       value = KEY_MAX;
								default: value = $urandom;
							endcase
						end
					endcase
				end
				send(mode, value);
				issued++;
				round_len--;
				// once, halfway through, let the block drain completely
				if (issued == target / 2)
					pause_sender(1, 1'b1);
			end
		end
	endtask

	// Receiver back-pressure: segments of no stall, light stall, heavy stall and
	// toggling, plus one long hold-off once traffic is under way.
	initial begin : rsp_backpressure
		int unsigned span;
		int unsigned style;
		bit          long_hold_done;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && requests_taken >= 300) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
			end
			span  = $urandom_range(120, 10);
			style = $urandom_range(3);
			repeat (span) begin
				case (style)
					0:       rsp_stall <= 1'b0;
					1:       rsp_stall <= ($urandom_range(7) == 0);
					2:       rsp_stall <= ($urandom_range(3) != 0);
					default: rsp_stall <= ~rsp_stall;
				endcase
				@(posedge clk);
			end
		end
	end

	// End the run if neither channel moves a transaction for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$error("no transaction for %0d cycles, %0d responses still owed", QUIET_LIMIT,
			board.outstanding());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : main_seq
		board = new();
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: search and remove must both miss at position 0.
		send(MODE_SEARCH, KEY_MIN);
		send(MODE_REMOVE, KEY_MIN);
		// Key extremes land at both ends of the table.
		send(MODE_INSERT, 0);
		send(MODE_INSERT, KEY_MIN);
		send(MODE_INSERT, KEY_MAX);
		send(MODE_SEARCH, KEY_MAX);
		send(MODE_SEARCH, -5);
		// Spare code acts as a search.
		send(MODE_SPARE, KEY_MAX);
		send(MODE_REMOVE, KEY_MIN);
		send(MODE_REMOVE, KEY_MAX);
		// Fill to capacity with keys that land on both sides of the ones held.
		for (int k = 1; k <= 15; k++)
			send(MODE_INSERT, (k % 2) ? -k * 1000 : k * 1000);
		// Full table refuses a new key, but a present key still reports duplicate.
		send(MODE_INSERT, 12345);
		send(MODE_INSERT, 0);
		pause_sender(1, 1'b1);

		run_random(RANDOM_ITEMS);
		pause_sender(1, 1'b1);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (board.outstanding() != 0) begin
			$error("%0d responses never arrived", board.outstanding());
			board.mismatches++;
		end
		$display("Covered %0d requests, %0d responses checked: %0d done, %0d duplicate,",
			requests_taken, board.checked, board.status_tally[ST_DONE],
			board.status_tally[ST_DUP]);
		$display("  %0d not found, %0d refused as full; table filled up %0d times.",
			board.status_tally[ST_ABSENT], board.status_tally[ST_FULL], board.full_hits);
		if (board.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sorted_set_table.f
+incdir+src
src/sst_pkg.sv
src/sst_ram.sv
src/sorted_set_table.sv
tb/sv/tb_sorted_set_table.sv
